>>> sv/assert_macros.svh
// Assertion macros shared by the RTL. Both forms take a label, a clock, an
// active-low reset and a property; the message goes to $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check prop at every rising edge of clk while out of reset.
`define HSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that cond never holds at a rising edge of clk while out of reset.
`define HSE_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define HSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define HSE_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> sv/hse_pkg.sv
`default_nettype none

package hse_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int STORE_DEPTH = 64;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // a read and a write request to the element store
    typedef struct packed {
        logic              rd_en;
        addr_t             rd_addr;
        logic              wr_en;
        addr_t             wr_addr;
        logic [DATA_W-1:0] wr_data;
    } mem_req_t;

    typedef enum logic [2:0] {
        T_LOAD,
        T_START,
        T_SORT,
        T_EMIT_RD,
        T_EMIT_LD
    } top_state_t;

    typedef enum logic [3:0] {
        SR_IDLE,
        SR_BUILD_NEXT,
        SR_ROOT_RD,
        SR_ROOT_LD,
        SR_LEFT_RD,
        SR_RIGHT_RD,
        SR_CMP,
        SR_PLACE,
        SR_EXT_NEXT,
        SR_EXT_RDK,
        SR_EXT_WR
    } sort_state_t;

endpackage

`default_nettype wire

>>> sv/heapsort_engine_unit.sv
//  channel | ports                                       | handshake
//  --------+---------------------------------------------+-----------------
//  input   | s_value[31:0] signed, s_last                | s_valid / s_ready
//  result  | m_sorted_value[31:0] signed, m_final_res,   | m_valid / m_ready
//          | m_overflow                                  |
//
//  Loading takes one word per cycle; s_ready is high only while loading.
//  The word with s_last starts the sort: heap build plus extraction run on a
//  single-port-read / single-port-write store. Emission then reads each word
//  from the store and loads it into the result register once that register
//  is free. aresetn is synchronous, active low; it clears count, flags and
//  states but leaves the store's contents. A stalled result holds its
//  register; the next set may start loading while the final result still
//  waits.
`default_nettype none
`include "assert_macros.svh"

module heapsort_engine_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic signed [hse_pkg::DATA_W-1:0] s_value,
    input  wire logic                           s_last,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic signed [hse_pkg::DATA_W-1:0]   m_sorted_value,
    output logic                                m_final_res,
    output logic                                m_overflow
);
    import hse_pkg::*;

    top_state_t state_reg, state_next;
    cnt_t       count_reg, count_next;
    logic       dropped_reg, dropped_next;
    addr_t      idx_reg, idx_next;

    logic       m_valid_reg, m_valid_next;
    data_t      m_value_reg, m_value_next;
    logic       m_final_reg, m_final_next;
    logic       m_ovf_reg, m_ovf_next;

    logic       in_fire;
    logic       out_free;
    logic       out_load;
    logic       is_final;

    mem_req_t                mem_req;
    mem_req_t                sort_req;
    logic [DATA_W-1:0]       rd_data;
    logic                    sort_start;
    logic                    sort_done;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign is_final = ({1'b0, idx_reg} + cnt_t'(1)) == count_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_LOAD:    if (in_fire && s_last) state_next = T_START;
            T_START:   state_next = T_SORT;
            T_SORT:    if (sort_done) state_next = T_EMIT_RD;
            T_EMIT_RD: state_next = T_EMIT_LD;
            T_EMIT_LD: begin
                if (out_free) begin
                    state_next = is_final ? T_LOAD : T_EMIT_RD;
                end
            end
            default:   state_next = T_LOAD;
        endcase
    end

    // outputs, store access and counters
    always_comb begin
        s_ready      = 1'b0;
        sort_start   = 1'b0;
        out_load     = 1'b0;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        idx_next     = idx_reg;
        mem_req      = '0;
        case (state_reg)
            T_LOAD: begin
                s_ready = 1'b1;
                if (in_fire) begin
                    // store while room is left, otherwise drop and flag
                    if (count_reg < cnt_t'(MAX_ITEMS)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = addr_t'(count_reg);
                        mem_req.wr_data = s_value;
                        count_next      = count_reg + cnt_t'(1);
                    end else begin
                        dropped_next = 1'b1;
                    end
                end
            end
            T_START: begin
                sort_start = 1'b1;
            end
            T_SORT: begin
                mem_req  = sort_req;
                idx_next = '0;
            end
            T_EMIT_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
            end
            T_EMIT_LD: begin
                if (out_free) begin
                    out_load = 1'b1;
                    idx_next = idx_reg + addr_t'(1);
                    if (is_final) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // result register: load a new word or drop the taken one
    always_comb begin
        m_valid_next = m_valid_reg;
        m_value_next = m_value_reg;
        m_final_next = m_final_reg;
        m_ovf_next   = m_ovf_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_value_next = data_t'(rd_data);
            m_final_next = is_final;
            m_ovf_next   = dropped_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg     <= idx_next;
        m_value_reg <= m_value_next;
        m_final_reg <= m_final_next;
        m_ovf_reg   <= m_ovf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_sorted_value = m_value_reg;
    assign m_final_res    = m_final_reg;
    assign m_overflow     = m_ovf_reg;

    hse_sorter u_sorter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sort_start),
        .len     (count_reg),
        .rd_data (rd_data),
        .mem_req (sort_req),
        .done    (sort_done)
    );

    // element store: one write and one registered read per cycle; the
    // sequencing never reads an entry in the cycle it is written
    hse_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    `HSE_NEVER(a_no_rw_clash, aclk, aresetn, mem_req.wr_en && mem_req.rd_en && mem_req.wr_addr == mem_req.rd_addr, "store read and write hit one entry")
    `HSE_ASSERT(a_done_in_sort, aclk, aresetn, sort_done |-> state_reg == T_SORT, "sort done outside sort phase")
    `HSE_ASSERT(a_final_clears, aclk, aresetn, out_load && is_final |=> count_reg == '0 && !dropped_reg, "final word did not end the set")
    `HSE_ASSERT(a_count_bound, aclk, aresetn, count_reg <= cnt_t'(MAX_ITEMS), "item count beyond capacity")

endmodule

`default_nettype wire

>>> sv/hse_ram.sv
`default_nettype none

module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                       aclk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // registered read, old data on a same-address write; read data holds
    // while rd_en is low
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> sv/hse_sorter.sv
`default_nettype none
`include "assert_macros.svh"

module hse_sorter (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire hse_pkg::cnt_t     len,
    input  wire logic [hse_pkg::DATA_W-1:0] rd_data,
    output hse_pkg::mem_req_t      mem_req,
    output logic                   done
);
    import hse_pkg::*;

    sort_state_t state_reg, state_next;
    cnt_t        len_reg, len_next;
    cnt_t        k_reg, k_next;
    cnt_t        hlen_reg, hlen_next;
    addr_t       node_reg, node_next;
    data_t       cur_reg, cur_next;
    data_t       tmp_reg, tmp_next;
    logic        build_reg, build_next;

    logic [CNT_W:0] left_idx;
    logic [CNT_W:0] right_idx;
    logic           has_left;
    logic           has_right;
    data_t          rd_val;
    logic           pick_left;
    logic           pick_right;
    logic           swap;
    data_t          top_val;
    addr_t          top_idx;

    // children of the current hole, and the larger of node/left/right
    always_comb begin
        left_idx   = {1'b0, node_reg, 1'b0} + (CNT_W+1)'(1);
        right_idx  = left_idx + (CNT_W+1)'(1);
        has_left   = left_idx < {1'b0, hlen_reg};
        has_right  = right_idx < {1'b0, hlen_reg};
        rd_val     = data_t'(rd_data);
        pick_left  = tmp_reg > cur_reg;
        pick_right = has_right && (rd_val > (pick_left ? tmp_reg : cur_reg));
        swap       = pick_left || pick_right;
        top_val    = pick_right ? rd_val : tmp_reg;
        top_idx    = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            SR_IDLE:       if (start) state_next = SR_BUILD_NEXT;
            SR_BUILD_NEXT: state_next = (k_reg == '0) ? SR_EXT_NEXT : SR_ROOT_RD;
            SR_ROOT_RD:    state_next = SR_ROOT_LD;
            SR_ROOT_LD:    state_next = SR_LEFT_RD;
            SR_LEFT_RD:    state_next = has_left ? SR_RIGHT_RD : SR_PLACE;
            SR_RIGHT_RD:   state_next = SR_CMP;
            SR_CMP:        state_next = swap ? SR_LEFT_RD : SR_PLACE;
            SR_PLACE:      state_next = build_reg ? SR_BUILD_NEXT : SR_EXT_NEXT;
            SR_EXT_NEXT:   state_next = (k_reg <= cnt_t'(1)) ? SR_IDLE : SR_EXT_RDK;
            SR_EXT_RDK:    state_next = SR_EXT_WR;
            SR_EXT_WR:     state_next = SR_LEFT_RD;
            default:       state_next = SR_IDLE;
        endcase
    end

    always_comb begin
        len_next   = len_reg;
        k_next     = k_reg;
        hlen_next  = hlen_reg;
        node_next  = node_reg;
        cur_next   = cur_reg;
        tmp_next   = tmp_reg;
        build_next = build_reg;
        mem_req    = '0;
        done       = 1'b0;
        case (state_reg)
            SR_IDLE: begin
                if (start) begin
                    len_next   = len;
                    k_next     = len >> 1;
                    build_next = 1'b1;
                end
            end
            SR_BUILD_NEXT: begin
                if (k_reg == '0) begin
                    k_next     = len_reg;
                    build_next = 1'b0;
                end else begin
                    node_next = addr_t'(k_reg - cnt_t'(1));
                    hlen_next = len_reg;
                    k_next    = k_reg - cnt_t'(1);
                end
            end
            SR_ROOT_RD: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = node_reg;
            end
            SR_ROOT_LD: begin
                cur_next = rd_val;
            end
            SR_LEFT_RD: begin
                mem_req.rd_en   = has_left;
                mem_req.rd_addr = left_idx[ADDR_W-1:0];
            end
            SR_RIGHT_RD: begin
                tmp_next        = rd_val;
                mem_req.rd_en   = has_right;
                mem_req.rd_addr = right_idx[ADDR_W-1:0];
            end
            SR_CMP: begin
                // move the larger child up into the hole
                if (swap) begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = node_reg;
                    mem_req.wr_data = top_val;
                    node_next       = top_idx;
                end
            end
            SR_PLACE: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = node_reg;
                mem_req.wr_data = cur_reg;
            end
            SR_EXT_NEXT: begin
                if (k_reg <= cnt_t'(1)) begin
                    done = 1'b1;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = '0;
                end
            end
            SR_EXT_RDK: begin
                tmp_next        = rd_val;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = addr_t'(k_reg - cnt_t'(1));
            end
            SR_EXT_WR: begin
                // old root to the tail, old tail becomes the hole's value
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = addr_t'(k_reg - cnt_t'(1));
                mem_req.wr_data = tmp_reg;
                cur_next        = rd_val;
                node_next       = '0;
                hlen_next       = k_reg - cnt_t'(1);
                k_next          = k_reg - cnt_t'(1);
            end
            default: begin
                done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SR_IDLE;
            build_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            build_reg <= build_next;
        end
        len_reg  <= len_next;
        k_reg    <= k_next;
        hlen_reg <= hlen_next;
        node_reg <= node_next;
        cur_reg  <= cur_next;
        tmp_reg  <= tmp_next;
    end

    `HSE_ASSERT(a_start_idle, aclk, aresetn, start |-> state_reg == SR_IDLE, "sorter started while busy")
    `HSE_ASSERT(a_hole_in_heap, aclk, aresetn, state_reg == SR_LEFT_RD |-> {1'b0, node_reg} < hlen_reg, "sift node outside heap")
    `HSE_ASSERT(a_write_in_set, aclk, aresetn, mem_req.wr_en |-> {1'b0, mem_req.wr_addr} < len_reg, "sorter write beyond set")

endmodule

`default_nettype wire

>>> bench/heapsort_engine_unit_tb.sv
// Testbench for heapsort_engine_unit.
//
// Words go in on the s_ channel, one value each. The word flagged with s_last
// closes the set and the block answers with the whole set in ascending order
// on the m_ channel. A shadow model in this bench keeps its own copy of the
// set and of the dropped flag, and it queues the expected sorted run at the
// moment the closing word is accepted. A checker process pops that queue
// once per accepted result word.
//
// Stimulus runs in named test tasks, in this order:
//   - extreme values (most negative, most positive, zero, +/-1)
//   - a set of one word
//   - a set full of equal values
//   - the store limit: the store fills exactly and the closing word, one
//     past it, is dropped but still starts the sort
//   - random short sets
//
// Both sides idle at random about 28 percent of the time. Part of the random
// phase runs with no idling at all so that back-to-back traffic is covered.
// Between random sets the bench does not wait for the results, so the next
// set loads while the final word of the previous run may still be waiting.
module heapsort_engine_unit_tb;

    import hse_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int IDLE_PCT     = 28;
    localparam int RANDOM_WORDS = 30;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 40;

    // one word of the sorted run as the block should present it
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     fin;
        logic                     ovf;
    } sorted_word_t;

    logic                     aclk           = 1'b0;
    logic                     aresetn        = 1'b0;
    logic                     s_valid        = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_value        = '0;
    logic                     s_last         = 1'b0;
    logic                     m_valid;
    logic                     m_ready        = 1'b0;
    logic signed [DATA_W-1:0] m_sorted_value;
    logic                     m_final_res;
    logic                     m_overflow;

    // shadow of the block's set under construction
    data_t        set_words [STORE_DEPTH];
    int           set_fill    = 0;
    logic         set_dropped = 1'b0;

    // sorted runs still owed by the block, oldest word first
    sorted_word_t sorted_due[$];

    int           fail_count  = 0;
    int           cycle_count = 0;
    logic         gaps_on     = 1'b1;
    logic         stalls_on   = 1'b1;

    heapsort_engine_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_final_res   (m_final_res),
        .m_overflow    (m_overflow)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Stall the result side at random; hold ready high while stalls are off.
    always @(posedge aclk) begin
        m_ready <= stalls_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles, %0d words still due",
                     $time, cycle_count, sorted_due.size());
            $display("heapsort_engine_unit verification failed");
            $finish;
        end
    end

    // Compare every accepted result word against the oldest one due.
    always @(posedge aclk) begin : check_words
        sorted_word_t due;
        if (aresetn && m_valid && m_ready) begin
            if (sorted_due.size() == 0) begin
                $display("%0t: result word with none due: expected none, actual value %0d",
                         $time, m_sorted_value);
                fail_count++;
            end else begin
                due = sorted_due.pop_front();
                if (m_sorted_value !== due.value) begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, due.value, m_sorted_value);
                    fail_count++;
                end
                if (m_final_res !== due.fin) begin
                    $display("%0t: final_res expected %0b actual %0b",
                             $time, due.fin, m_final_res);
                    fail_count++;
                end
                if (m_overflow !== due.ovf) begin
                    $display("%0t: overflow expected %0b actual %0b",
                             $time, due.ovf, m_overflow);
                    fail_count++;
                end
            end
        end
    end

    // Update the shadow set with one accepted word; on the closing word,
    // order the set and queue the whole run.
    task automatic absorb_word(input data_t v, input logic lst);
        data_t        ordered [STORE_DEPTH];
        data_t        hold;
        int           j;
        sorted_word_t w;
        if (set_fill < MAX_ITEMS) begin
            set_words[set_fill] = v;
            set_fill++;
        end else begin
            set_dropped = 1'b1;
        end
        if (lst) begin
            for (int i = 0; i < set_fill; i++) ordered[i] = set_words[i];
            // insertion sort, signed compare on data_t
            for (int i = 1; i < set_fill; i++) begin
                hold = ordered[i];
                j    = i - 1;
                while (j >= 0 && ordered[j] > hold) begin
                    ordered[j+1] = ordered[j];
                    j--;
                end
                ordered[j+1] = hold;
            end
            for (int i = 0; i < set_fill; i++) begin
                w.value = ordered[i];
                w.fin   = (i == set_fill - 1);
                w.ovf   = set_dropped;
                sorted_due.push_back(w);
            end
            set_fill    = 0;
            set_dropped = 1'b0;
        end
    endtask

    // Offer one word and wait for its handshake. Call at a rising edge.
    // Valid is lowered only inside an idle gap, so a word that follows
    // directly keeps valid high without a second assignment in the step.
    task automatic send_word(input data_t v, input logic lst);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_value <= v;
        s_last  <= lst;
        do @(posedge aclk); while (!s_ready);
        absorb_word(v, lst);
    endtask

    // Mix full-range values with a narrow band that forces repeats.
    function automatic data_t pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60) return data_t'($urandom);
        if (roll < 90) return data_t'(int'($urandom_range(8)) - 4);
        if (roll < 95) return {1'b1, {(DATA_W-1){1'b0}}};
        return {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    task automatic send_set(input int len);
        for (int k = 0; k < len; k++) send_word(pick_value(), k == len - 1);
    endtask

    // Drop valid and wait until every result word due has arrived.
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sorted_due.size() != 0);
    endtask

    task automatic test_extremes();
        send_word({1'b0, {(DATA_W-1){1'b1}}}, 1'b0);
        send_word({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
        send_word(data_t'(0), 1'b0);
        send_word(data_t'(-1), 1'b0);
        send_word(data_t'(1), 1'b0);
        send_word({1'b1, {(DATA_W-1){1'b0}}}, 1'b0);
        send_word({1'b0, {(DATA_W-1){1'b1}}}, 1'b1);
        settle();
    endtask

    task automatic test_single_word();
        send_word(data_t'(32'h5A5A_A5A5), 1'b1);
        settle();
    endtask

    // Equal values must come out as plain ascending order.
    task automatic test_equal_values();
        send_word(data_t'(7), 1'b0);
        send_word(data_t'(7), 1'b0);
        send_word(data_t'(-3), 1'b0);
        send_word(data_t'(7), 1'b0);
        send_word(data_t'(-3), 1'b0);
        send_word(data_t'(7), 1'b1);
        settle();
    endtask

    // Fill the store exactly and overrun it by one word; the closing word
    // is dropped yet still starts the sort.
    task automatic test_store_limits();
        send_set(MAX_ITEMS + 1);
        settle();
    endtask

    // Random short sets; the next set is offered without waiting for results.
    // Run a middle stretch with no idling on either side.
    task automatic test_random_sets();
        int sent;
        int len;
        sent = 0;
        while (sent < RANDOM_WORDS) begin
            len       = $urandom_range(1, 12);
            gaps_on   = !(sent >= 8 && sent < 22);
            stalls_on = gaps_on;
            send_set(len);
            sent += len;
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        settle();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_single_word();
        test_equal_values();
        test_store_limits();
        test_random_sets();

        // let any stray result word surface before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("heapsort_engine_unit verification clean");
        end else begin
            $display("heapsort_engine_unit verification failed");
        end
        $finish;
    end

endmodule
